// ===== hw/rtl/divide_blend_pixel_macros.svh =====
// Assertion macros shared by the divide blend pixel RTL.
`ifndef DIVIDE_BLEND_PIXEL_MACROS_SVH
`define DIVIDE_BLEND_PIXEL_MACROS_SVH

// Implication checked at every rising edge of clk, off while in reset.
`define DBP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dbp_pkg.sv =====
// Types and constants shared by the divide blend pixel block.
`timescale 1ns / 1ps

package dbp_pkg;

    localparam int FIELD_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_HAS_ALPHA = 1'd1;

    // Result format codes
    localparam logic [2:0] FMT_RGBA       = 3'd0;
    localparam logic [2:0] FMT_RGB        = 3'd1;
    localparam logic [2:0] FMT_GRAY_ALPHA = 3'd2;
    localparam logic [2:0] FMT_GRAY       = 3'd3;
    localparam logic [2:0] FMT_ALPHA      = 3'd4;

    typedef struct packed {
        logic [FIELD_W-1:0] bottom_red;
        logic [FIELD_W-1:0] bottom_green;
        logic [FIELD_W-1:0] bottom_blue;
        logic [FIELD_W-1:0] bottom_alpha;
        logic [FIELD_W-1:0] top_red;
        logic [FIELD_W-1:0] top_green;
        logic [FIELD_W-1:0] top_blue;
        logic [FIELD_W-1:0] top_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_red;
        logic [FIELD_W-1:0] out_green;
        logic [FIELD_W-1:0] out_blue;
        logic [FIELD_W-1:0] out_alpha;
    } pixel_out_t;

endpackage

// ===== hw/rtl/divide_blend_pixel.sv =====
// Divide blend of one bottom pixel by one top pixel, fully pipelined.
`timescale 1ns / 1ps
//
// Usage
//   Input: drive a pixel transaction on pixel and raise start. The transaction is
//   taken at a rising edge where start is high and busy is low. busy is high only
//   while rst_n is asserted and in the first cycle after it; afterwards the block
//   takes one pixel every cycle with no gaps.
//   Output: each result transaction sits on result for exactly one cycle, marked
//   by done. The receiver cannot hold it off, so the pipeline never stalls and
//   no transaction is ever dropped or repeated.
//   Most of the pipeline is the restoring divider, which resolves one quotient
//   bit per stage. Throughput: one pixel per cycle.
//   Stages: input register, CHANNEL_BITS restoring-divide stages plus their entry
//   stage, two mix stages (multiply, then add), and an output stage that divides
//   by the all-ones channel value and applies the result format.
//   Configuration: write result_format (index 0) and top_has_alpha (index 1) via
//   cfg_we / cfg_index / cfg_wdata only while no transaction is in flight.
//   Reset: clears all valid bits and loads result_format = rgb, top_has_alpha = 0.

module divide_blend_pixel #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dbp_pkg::pixel_in_t                   pixel,
    output logic                                 done,
    output dbp_pkg::pixel_out_t                  result,
    input  logic                                 cfg_we,
    input  logic [dbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dbp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import dbp_pkg::*;

    `include "divide_blend_pixel_macros.svh"

    localparam int CB  = CHANNEL_BITS;
    localparam int NW  = 2 * CHANNEL_BITS;
    localparam int NL  = 3;                    // red, green, blue lanes
    localparam int LAT = CHANNEL_BITS + 5;     // accept edge to done sample edge

    typedef logic [CB-1:0] lane_t;
    typedef logic [NW-1:0] wide_t;

    localparam lane_t MAXV = {CB{1'b1}};
    localparam lane_t HALF = MAXV >> 1;
    localparam logic [FIELD_W-1:0] LANE_MASK = FIELD_W'(MAXV);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] fmt_reg;
    logic       mix_reg;
    logic       busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_RGB;
            mix_reg  <= 1'b0;
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RESULT_FORMAT: fmt_reg <= cfg_wdata;
                    REG_TOP_HAS_ALPHA: mix_reg <= cfg_wdata[0];
                    default:           fmt_reg <= fmt_reg;
                endcase
            end
        end
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // ------------------------------------------------------------------
    // Stage A: capture the pixel, narrowed to channel lanes
    // ------------------------------------------------------------------
    lane_t a_b_next [NL];
    lane_t a_t_next [NL];

    always_comb
    begin
        a_b_next[0] = CB'(pixel.bottom_red);
        a_b_next[1] = CB'(pixel.bottom_green);
        a_b_next[2] = CB'(pixel.bottom_blue);
        a_t_next[0] = CB'(pixel.top_red);
        a_t_next[1] = CB'(pixel.top_green);
        a_t_next[2] = CB'(pixel.top_blue);
    end

    logic  a_valid_reg;
    lane_t a_b_reg [NL];
    lane_t a_t_reg [NL];
    lane_t a_ba_reg;
    lane_t a_ta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        a_b_reg  <= a_b_next;
        a_t_reg  <= a_t_next;
        a_ba_reg <= CB'(pixel.bottom_alpha);
        a_ta_reg <= CB'(pixel.top_alpha);
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 forms bottom * MAXV and the saturation flag, then
    // each of the CB stages resolves one quotient bit (restoring).
    // Saturation: top is zero, or bottom > top (quotient would pass MAXV).
    // ------------------------------------------------------------------
    logic  d_valid_reg [CB+1];
    lane_t d_q_reg     [CB+1][NL];
    lane_t d_b_reg     [CB+1][NL];
    logic  d_sat_reg   [CB+1][NL];
    lane_t d_ba_reg    [CB+1];
    lane_t d_ta_reg    [CB+1];
    lane_t d_rem_reg   [CB][NL];
    lane_t d_low_reg   [CB][NL];
    lane_t d_t_reg     [CB][NL];

    wide_t d0_n_next   [NL];
    logic  d0_sat_next [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            d0_n_next[l]   = (NW'(a_b_reg[l]) << CB) - NW'(a_b_reg[l]);
            d0_sat_next[l] = (a_t_reg[l] == '0) || (a_b_reg[l] > a_t_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg[0] <= 1'b0;
        else
            d_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            d_q_reg[0][l]   <= '0;
            d_b_reg[0][l]   <= a_b_reg[l];
            d_sat_reg[0][l] <= d0_sat_next[l];
            d_rem_reg[0][l] <= d0_n_next[l][NW-1:CB];
            d_low_reg[0][l] <= d0_n_next[l][CB-1:0];
            d_t_reg[0][l]   <= a_t_reg[l];
        end
        d_ba_reg[0] <= a_ba_reg;
        d_ta_reg[0] <= a_ta_reg;
    end

    for (genvar k = 0; k < CB; k++)
    begin : g_div
        logic [CB:0] trial     [NL];
        logic [CB:0] diff      [NL];
        logic        ge        [NL];
        lane_t       rem_next  [NL];
        lane_t       q_next    [NL];

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                trial[l]    = {d_rem_reg[k][l], d_low_reg[k][l][CB-1]};
                diff[l]     = trial[l] - {1'b0, d_t_reg[k][l]};
                ge[l]       = trial[l] >= {1'b0, d_t_reg[k][l]};
                rem_next[l] = ge[l] ? diff[l][CB-1:0] : trial[l][CB-1:0];
                q_next[l]   = {d_q_reg[k][l][CB-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid_reg[k+1] <= 1'b0;
            else
                d_valid_reg[k+1] <= d_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < NL; l++)
            begin
                d_q_reg[k+1][l]   <= q_next[l];
                d_b_reg[k+1][l]   <= d_b_reg[k][l];
                d_sat_reg[k+1][l] <= d_sat_reg[k][l];
            end
            d_ba_reg[k+1] <= d_ba_reg[k];
            d_ta_reg[k+1] <= d_ta_reg[k];
        end

        if (k + 1 < CB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    d_rem_reg[k+1][l] <= rem_next[l];
                    d_low_reg[k+1][l] <= d_low_reg[k][l] << 1;
                    d_t_reg[k+1][l]   <= d_t_reg[k][l];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Mix stage 1: saturate the quotient and form both products
    // ------------------------------------------------------------------
    lane_t m_q_next [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            m_q_next[l] = d_sat_reg[CB][l] ? MAXV : d_q_reg[CB][l];
    end

    logic  m_valid_reg;
    wide_t m_p0_reg [NL];
    wide_t m_p1_reg [NL];
    lane_t m_q_reg  [NL];
    lane_t m_ba_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= d_valid_reg[CB];
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            m_p0_reg[l] <= NW'(d_b_reg[CB][l]) * NW'(MAXV - d_ta_reg[CB]);
            m_p1_reg[l] <= NW'(m_q_next[l]) * NW'(d_ta_reg[CB]);
            m_q_reg[l]  <= m_q_next[l];
        end
        m_ba_reg <= d_ba_reg[CB];
    end

    // ------------------------------------------------------------------
    // Mix stage 2: add the products and the rounding half
    // ------------------------------------------------------------------
    logic  s_valid_reg;
    wide_t s_sum_reg [NL];
    lane_t s_q_reg   [NL];
    lane_t s_ba_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            s_sum_reg[l] <= m_p0_reg[l] + m_p1_reg[l] + NW'(HALF);
            s_q_reg[l]   <= m_q_reg[l];
        end
        s_ba_reg <= m_ba_reg;
    end

    // ------------------------------------------------------------------
    // Output stage: divide by MAXV = 2^CB - 1 as sum >> CB plus one
    // correction (the remainder stays below twice MAXV), pick the mixed or
    // plain quotient, then apply the result format.
    // ------------------------------------------------------------------
    lane_t       div_q0   [NL];
    logic [CB:0] div_rem  [NL];
    lane_t       lane_val [NL];
    pixel_out_t  result_next;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            div_q0[l]   = s_sum_reg[l][NW-1:CB];
            div_rem[l]  = {1'b0, s_sum_reg[l][CB-1:0]} + {1'b0, div_q0[l]};
            lane_val[l] = mix_reg ? div_q0[l] + lane_t'(div_rem[l] >= {1'b0, MAXV})
                                  : s_q_reg[l];
        end

        result_next.out_red   = FIELD_W'(lane_val[0]);
        result_next.out_green = FIELD_W'(lane_val[1]);
        result_next.out_blue  = FIELD_W'(lane_val[2]);
        result_next.out_alpha = LANE_MASK;

        unique case (fmt_reg) inside
            FMT_RGBA:
            begin
                result_next.out_alpha = FIELD_W'(s_ba_reg);
            end
            FMT_GRAY_ALPHA:
            begin
                result_next.out_green = '0;
                result_next.out_blue  = '0;
                result_next.out_alpha = FIELD_W'(s_ba_reg);
            end
            FMT_GRAY, FMT_ALPHA:
            begin
                result_next.out_green = '0;
                result_next.out_blue  = '0;
            end
            default:
            begin
                // rgb, and the undefined codes behave as rgb
                result_next.out_alpha = LANE_MASK;
            end
        endcase
    end

    logic       done_reg;
    pixel_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DBP_ASSERT_IMPLIES(a_done_has_source, done, $past(accept, LAT),
        "result strobe without a transaction accepted at the pipeline latency")
    `DBP_ASSERT_IMPLIES(a_zero_divisor_saturates,
        done && !mix_reg && $past((pixel.top_red & LANE_MASK) == '0, LAT),
        result.out_red == LANE_MASK,
        "zero red divisor did not saturate the red lane")
    `DBP_ASSERT_IMPLIES(a_zero_weight_keeps_bottom,
        done && mix_reg && $past((pixel.top_alpha & LANE_MASK) == '0, LAT),
        result.out_red == ($past(pixel.bottom_red, LAT) & LANE_MASK),
        "mix with zero top alpha did not return the bottom red value")
    `DBP_ASSERT_NEXT(a_busy_clears_after_reset, busy, !busy,
        "busy held past the first cycle after reset")

endmodule
